/* design/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge, b must hold at the next edge
`define AST_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("next-cycle check failed");

// a holds at an edge, b must hold at the same edge
`define AST_SAME(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("same-cycle check failed");

`endif

/* design/dsas_pkg.sv */
package dsas_pkg;

    localparam int MAX_LEN_LOG2 = 10;
    localparam int SAMPLE_BITS  = 24;
    localparam int BIN_W        = 10;
    localparam int LEN_W        = BIN_W + 1;
    localparam int STORE_DEPTH  = 1 << MAX_LEN_LOG2;
    localparam int SUM_W        = 40;
    localparam int SQ_W         = 2 * SAMPLE_BITS;
    localparam int AVG_W        = 24;
    localparam int LINES_W      = 16;
    localparam int WIN_W        = 7;
    localparam int LLOG_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int ACC_W        = 31;
    localparam int DIV_CNT_W    = 6;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ACCUM = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQRT,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_START,
        ST_RD_ISSUE,
        ST_RD_DIVST,
        ST_RD_DIV,
        ST_RD_ADD,
        ST_WIN_DIVST,
        ST_WIN_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic clr_start;
        logic clr_step;
        logic sq_a;
        logic sq_b;
        logic sqrt_step;
        logic acc_rd;
        logic acc_wr;
        logic rd_start;
        logic rd_issue;
        logic div_start_sum;
        logic div_start_win;
        logic div_step;
        logic rd_capture;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sqrt_last;
        logic div_last;
        logic win_last;
        logic out_free;
    } dp_status_t;

endpackage

/* design/dsas_ctrl.sv */
module dsas_ctrl
    import dsas_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_command,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    case (s_command)
                        CMD_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        CMD_ACCUM: state_next = ST_SQ_A;
                        CMD_READ:  state_next = ST_RD_START;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQ_A: begin
                cmd.sq_a   = 1'b1;
                state_next = ST_SQ_B;
            end
            ST_SQ_B: begin
                cmd.sq_b   = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last) begin
                    state_next = ST_ACC_RD;
                end
            end
            ST_ACC_RD: begin
                cmd.acc_rd = 1'b1;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_START: begin
                cmd.rd_start = 1'b1;
                state_next   = ST_RD_ISSUE;
            end
            ST_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_DIVST;
            end
            ST_RD_DIVST: begin
                cmd.div_start_sum = 1'b1;
                state_next        = ST_RD_DIV;
            end
            ST_RD_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_RD_ADD;
                end
            end
            ST_RD_ADD: begin
                cmd.rd_capture = 1'b1;
                state_next     = status.win_last ? ST_WIN_DIVST : ST_RD_ISSUE;
            end
            ST_WIN_DIVST: begin
                cmd.div_start_win = 1'b1;
                state_next        = ST_WIN_DIV;
            end
            ST_WIN_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

/* design/dsas_datapath.sv */
module dsas_datapath
    import dsas_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] s_re_part,
    input  logic signed [SAMPLE_BITS-1:0] s_im_part,
    input  logic [BIN_W-1:0]              s_read_bin,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [BIN_W-1:0]              m_bin_out,
    output logic [AVG_W-1:0]              m_raw_average,
    output logic [AVG_W-1:0]              m_smoothed_average,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status
);

    function automatic logic [SAMPLE_BITS-1:0] abs_val(input logic [SAMPLE_BITS-1:0] x);
        return x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    // configuration
    logic [LLOG_W-1:0]  len_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [WIN_W-1:0]   win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= LLOG_W'(MAX_LEN_LOG2);
            lines_reg <= LINES_W'(1);
            win_reg   <= WIN_W'(7);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEN_LOG2:  len_reg   <= cfg_data[LLOG_W-1:0];
                REG_NUM_LINES: lines_reg <= cfg_data[LINES_W-1:0];
                REG_WINDOW:    win_reg   <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LLOG_W-1:0]  len_eff;
    logic [BIN_W-1:0]   mask;
    logic [BIN_W-1:0]   half;
    logic [LINES_W-1:0] lines_eff;
    logic [WIN_W-1:0]   win_eff;
    logic [WIN_W-2:0]   half_win;

    always_comb begin
        len_eff   = (len_reg > LLOG_W'(MAX_LEN_LOG2)) ? LLOG_W'(MAX_LEN_LOG2) : len_reg;
        mask      = BIN_W'((LEN_W'(1) << len_eff) - LEN_W'(1));
        half      = BIN_W'((LEN_W'(1) << len_eff) >> 1);
        lines_eff = (lines_reg == '0) ? LINES_W'(1) : lines_reg;
        win_eff   = (win_reg == '0) ? WIN_W'(1) : win_reg;
        half_win  = (WIN_W-1)'((win_eff - WIN_W'(1)) >> 1);
    end

    // item registers
    logic [SAMPLE_BITS-1:0] re_reg, im_reg;
    logic [BIN_W-1:0]       rbin_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            re_reg   <= s_re_part;
            im_reg   <= s_im_part;
            rbin_reg <= s_read_bin;
        end
    end

    // squares and bit-serial square root
    logic [SAMPLE_BITS-1:0] abs_re, abs_im;
    logic [SQ_W-1:0]        sq_reg;
    logic [SQ_W-1:0]        v_reg, res_reg, bit_reg;
    logic [SQ_W-1:0]        sqrt_try;

    assign abs_re   = abs_val(re_reg);
    assign abs_im   = abs_val(im_reg);
    assign sqrt_try = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sq_a) begin
            sq_reg <= abs_re * abs_re;
        end
        if (cmd.sq_b) begin
            v_reg   <= sq_reg + abs_im * abs_im;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (cmd.sqrt_step) begin
            if (v_reg >= sqrt_try) begin
                v_reg   <= v_reg - sqrt_try;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // bin store, clearing sweep and bin counter
    logic [SUM_W-1:0] mem [STORE_DEPTH];
    logic [SUM_W-1:0] rdata_reg;
    logic [BIN_W-1:0] clr_addr_reg;
    logic [BIN_W-1:0] next_bin_reg;
    logic [BIN_W-1:0] nb_idx;
    logic [BIN_W-1:0] widx_reg;
    logic [SUM_W:0]   sum_ext;
    logic             mem_we;
    logic [BIN_W-1:0] waddr, raddr;
    logic [SUM_W-1:0] wdata;

    assign nb_idx  = next_bin_reg & mask;
    assign sum_ext = {1'b0, rdata_reg} + (SUM_W+1)'(res_reg);

    always_comb begin
        mem_we = cmd.clr_step | cmd.acc_wr;
        waddr  = cmd.clr_step ? clr_addr_reg : nb_idx;
        wdata  = cmd.clr_step ? '0 : (sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0]);
        raddr  = cmd.acc_rd ? nb_idx : widx_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            next_bin_reg <= '0;
        end else begin
            if (cmd.clr_start) begin
                clr_addr_reg <= '0;
                next_bin_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.acc_wr) begin
                next_bin_reg <= (nb_idx + 1'b1) & mask;
            end
        end
    end

    // window sum, also the dividend of the final division
    logic [ACC_W-1:0] acc_reg;

    // shared restoring divider, one quotient bit per cycle
    logic [SUM_W-1:0]     dvd_reg;
    logic [LINES_W:0]     rem_reg;
    logic [LINES_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [LINES_W:0]     rem_try;
    logic                 q_bit;

    assign rem_try = {rem_reg[LINES_W-1:0], dvd_reg[SUM_W-1]};
    assign q_bit   = (rem_try >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_start_sum || cmd.div_start_win) begin
            dvd_reg  <= cmd.div_start_sum ? rdata_reg : SUM_W'(acc_reg);
            dvs_reg  <= cmd.div_start_sum ? lines_eff : LINES_W'(win_eff);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= q_bit ? (rem_try - {1'b0, dvs_reg}) : rem_try;
            dvd_reg  <= {dvd_reg[SUM_W-2:0], q_bit};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    logic [AVG_W-1:0] quot_sat;
    assign quot_sat = (dvd_reg[SUM_W-1:AVG_W] != '0) ? '1 : dvd_reg[AVG_W-1:0];

    // window walk
    logic [WIN_W-1:0] k_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [AVG_W-1:0] raw_reg;
    logic [BIN_W-1:0] bin_m, centre;

    assign bin_m  = rbin_reg & mask;
    assign centre = (bin_m + half) & mask;

    always_ff @(posedge aclk) begin
        if (cmd.rd_start) begin
            bin_reg  <= bin_m;
            widx_reg <= (centre - BIN_W'(half_win)) & mask;
            k_reg    <= '0;
            acc_reg  <= '0;
        end else if (cmd.rd_capture) begin
            acc_reg  <= acc_reg + ACC_W'(quot_sat);
            k_reg    <= k_reg + 1'b1;
            widx_reg <= (widx_reg + 1'b1) & mask;
            if (k_reg == WIN_W'(half_win)) begin
                raw_reg <= quot_sat;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_bin_out          <= bin_reg;
            m_raw_average      <= raw_reg;
            m_smoothed_average <= quot_sat;
        end
    end

    always_comb begin
        status.clr_last  = (clr_addr_reg == BIN_W'(STORE_DEPTH - 1));
        status.sqrt_last = bit_reg[0];
        status.div_last  = (dcnt_reg == DIV_CNT_W'(SUM_W - 1));
        status.win_last  = (k_reg == {half_win, 1'b0});
        status.out_free  = !m_valid || m_ready;
    end

endmodule

/* design/doppler_spectrum_average_smooth.sv */
// averaged magnitude spectrum with a circular moving-average readout. command 0 clears the
// 1024-entry bin store and the bin counter by a sweep, also run once after reset; no request
// is taken during the sweep, configuration writes are. command 1 adds floor(sqrt(re^2+im^2))
// to the current bin by squaring both parts, the bit-serial root, a store read and a write.
// command 2 returns one result, computed by the shared 40-step divider, used once per window
// term and once for the final window division. a finished result waits in the output register
// while the next request is taken.
module doppler_spectrum_average_smooth
    import dsas_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic signed [SAMPLE_BITS-1:0] s_re_part,
    input  logic signed [SAMPLE_BITS-1:0] s_im_part,
    input  logic [BIN_W-1:0]              s_read_bin,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [BIN_W-1:0]              m_bin_out,
    output logic [AVG_W-1:0]              m_raw_average,
    output logic [AVG_W-1:0]              m_smoothed_average
);

    // command and status between controller and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: one request at a time
    dsas_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // store, root unit, divider and output register
    dsas_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_re_part          (s_re_part),
        .s_im_part          (s_im_part),
        .s_read_bin         (s_read_bin),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bin_out          (m_bin_out),
        .m_raw_average      (m_raw_average),
        .m_smoothed_average (m_smoothed_average),
        .cmd                (cmd),
        .status             (status)
    );

endmodule

/* design/dsas_checker.sv */
`include "assert_macros.svh"

module dsas_checker
    import dsas_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [1:0]       s_command,
    input logic             m_valid,
    input logic             m_ready,
    input logic [AVG_W-1:0] m_smoothed_average
);

    // a stalled result keeps its payload
    `AST_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_smoothed_average))
    // a clear request starts the sweep, no request taken next
    `AST_NEXT(a_clear_busy, s_valid && s_ready && s_command == CMD_CLEAR, !s_ready)
    // an accumulate request never raises a result
    `AST_NEXT(a_accum_silent, s_valid && s_ready && s_command == CMD_ACCUM, !$rose(m_valid))
    // a read request leaves the block busy, no request taken next
    `AST_NEXT(a_read_busy, s_valid && s_ready && s_command == CMD_READ, !s_ready)

endmodule

bind doppler_spectrum_average_smooth dsas_checker u_chk (.*);

/* sim/tb_doppler_spectrum_average_smooth.sv */
`default_nettype none

module tb_doppler_spectrum_average_smooth;
    timeunit 1ns;
    timeprecision 1ps;

    import dsas_pkg::*;

    // generous ceiling on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 12000000;
    // quiet time before a register write, covers a full clear sweep
    localparam int SETTLE_CYCLES = 1200;
    localparam int PHASE_ITEMS = 160;
    localparam int NUM_PHASES = 10;
    localparam int NUM_DIRECTED = 14;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one bin report as the block should return it
    typedef struct {
        logic [BIN_W-1:0] bin;
        logic [AVG_W-1:0] raw;
        logic [AVG_W-1:0] smooth;
    } bin_report_t;

    // directed request, with a typed-in report where it is obvious
    typedef struct {
        logic [1:0]                    cmd;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic [BIN_W-1:0]              rbin;
        bit                            fixed;
        bin_report_t                   report;
    } directed_row_t;

    // register setting for one phase of the random part
    typedef struct {
        logic [LLOG_W-1:0]  len_log2;
        logic [LINES_W-1:0] lines;
        logic [WIN_W-1:0]   window;
    } phase_setting_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = REG_LEN_LOG2;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_command = CMD_CLEAR;
    logic signed [SAMPLE_BITS-1:0] s_re_part = '0;
    logic signed [SAMPLE_BITS-1:0] s_im_part = '0;
    logic [BIN_W-1:0]              s_read_bin = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [BIN_W-1:0]              m_bin_out;
    logic [AVG_W-1:0]              m_raw_average;
    logic [AVG_W-1:0]              m_smoothed_average;

    doppler_spectrum_average_smooth uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_re_part          (s_re_part),
        .s_im_part          (s_im_part),
        .s_read_bin         (s_read_bin),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bin_out          (m_bin_out),
        .m_raw_average      (m_raw_average),
        .m_smoothed_average (m_smoothed_average)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // shadow of the spectrum store and its settings
    logic [SUM_W-1:0]   shadow_sums [STORE_DEPTH];
    logic [BIN_W-1:0]   shadow_next_bin = '0;
    logic [LLOG_W-1:0]  shadow_len_log2 = 4'd10;
    logic [LINES_W-1:0] shadow_lines = 16'd1;
    logic [WIN_W-1:0]   shadow_window = 7'd7;

    bin_report_t pending_reports [$];
    int error_count = 0;
    int burst_left = 0;
    int cycle_count = 0;

    initial begin
        foreach (shadow_sums[i]) shadow_sums[i] = '0;
    end

    // floor of the square root, built up one result bit at a time
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int i = 24; i >= 0; i--) begin
            trial = res | (64'd1 << i);
            if (trial * trial <= v)
                res = trial;
        end
        return res;
    endfunction

    function automatic longint unsigned spectrum_len();
        return 64'd1 << ((shadow_len_log2 > MAX_LEN_LOG2) ? MAX_LEN_LOG2 : shadow_len_log2);
    endfunction

    // line average of one bin, divisor zero treated as one, clipped to the output width
    function automatic longint unsigned line_average(longint unsigned idx);
        longint unsigned d;
        longint unsigned q;
        d = (shadow_lines == 0) ? 1 : shadow_lines;
        q = shadow_sums[idx % STORE_DEPTH] / d;
        return (q > 64'hFF_FFFF) ? 64'hFF_FFFF : q;
    endfunction

    // fold one magnitude into the current bin, saturating the sum
    task automatic accumulate_bin(logic signed [SAMPLE_BITS-1:0] re,
                                  logic signed [SAMPLE_BITS-1:0] im);
        longint a;
        longint b;
        longint unsigned n;
        longint unsigned idx;
        longint unsigned total;
        a = re;
        b = im;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        n = spectrum_len();
        idx = shadow_next_bin & (n - 1);
        total = shadow_sums[idx] + floor_root(a * a + b * b);
        shadow_sums[idx] = (total > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : SUM_W'(total);
        shadow_next_bin = BIN_W'((idx + 1) & (n - 1));
    endtask

    // report for one bin: raw average and circular window average at the shifted bin
    function automatic bin_report_t read_bin_report(logic [BIN_W-1:0] rbin);
        bin_report_t r;
        longint unsigned n;
        longint unsigned bin;
        longint unsigned centre;
        longint unsigned w;
        longint unsigned half;
        longint unsigned acc;
        longint unsigned sm;
        n = spectrum_len();
        bin = rbin & (n - 1);
        centre = (bin + n / 2) & (n - 1);
        w = (shadow_window == 0) ? 1 : shadow_window;
        half = (w - 1) / 2;
        acc = 0;
        for (longint unsigned k = 0; k <= 2 * half; k++)
            acc += line_average((centre + k + n * 128 - half) & (n - 1));
        sm = acc / w;
        r.bin = BIN_W'(bin);
        r.raw = AVG_W'(line_average(centre));
        r.smooth = (sm > 64'hFF_FFFF) ? 24'hFF_FFFF : AVG_W'(sm);
        return r;
    endfunction

    // push one request through the handshake and update the shadow on acceptance
    task automatic send_request(logic [1:0] cmd, logic signed [SAMPLE_BITS-1:0] re,
                                logic signed [SAMPLE_BITS-1:0] im, logic [BIN_W-1:0] rbin,
                                bit fixed, bin_report_t fixed_report);
        int gap;
        // burst ended: maybe leave a gap before the next one
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_re_part  <= re;
        s_im_part  <= im;
        s_read_bin <= rbin;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        case (cmd)
            CMD_CLEAR: begin
                foreach (shadow_sums[i]) shadow_sums[i] = '0;
                shadow_next_bin = '0;
            end
            CMD_ACCUM: accumulate_bin(re, im);
            CMD_READ:  pending_reports.push_back(fixed ? fixed_report : read_bin_report(rbin));
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LEN_LOG2:  shadow_len_log2 = value[LLOG_W-1:0];
            REG_NUM_LINES: shadow_lines = value[LINES_W-1:0];
            REG_WINDOW:    shadow_window = value[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // drop valid, let every report drain and any sweep or sum finish
    task automatic drain_block();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // sample value, pinned to the extremes now and then
    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return SAMPLE_BITS'($urandom_range(0, 15));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // result side: stall pattern changes every so often, checks on each handshake
    int stall_mode = 0;
    int stall_age = 0;
    always @(posedge aclk) begin
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result with no request waiting: bin_out %0d", m_bin_out);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_bin_out !== want.bin) begin
                    $error("bin_out expected %0d actual %0d", want.bin, m_bin_out);
                    error_count++;
                end
                if (m_raw_average !== want.raw) begin
                    $error("raw_average expected %0d actual %0d", want.raw, m_raw_average);
                    error_count++;
                end
                if (m_smoothed_average !== want.smooth) begin
                    $error("smoothed_average expected %0d actual %0d", want.smooth,
                           m_smoothed_average);
                    error_count++;
                end
            end
        end
        if (stall_age == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_age = $urandom_range(8, 200);
        end
        stall_age--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (cycle_count % 5 == 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // directed requests under the reset settings: 1024 bins, one line, window 7
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // empty store reads back zero
        '{CMD_READ,  24'sd0, 24'sd0, 10'd0,    1'b1, '{10'd0, 24'd0, 24'd0}},
        '{CMD_READ,  24'sd0, 24'sd0, 10'd1023, 1'b1, '{10'd1023, 24'd0, 24'd0}},
        // largest magnitude into bin 0, seen from the read of bin 512
        '{CMD_ACCUM, 24'sh800000, 24'sh800000, 10'd0, 1'b0, '{'0, '0, '0}},
        '{CMD_READ,  24'sd0, 24'sd0, 10'd512,  1'b1, '{10'd512, 24'd11863283, 24'd1694754}},
        '{CMD_ACCUM, 24'sh7FFFFF, 24'sh7FFFFF, 10'd0, 1'b0, '{'0, '0, '0}},
        '{CMD_ACCUM, 24'sd0, 24'sd0, 10'd0,    1'b0, '{'0, '0, '0}},
        '{CMD_ACCUM, -24'sd1, 24'sd1, 10'd0,   1'b0, '{'0, '0, '0}},
        '{CMD_ACCUM, 24'sh7FFFFF, 24'sh800000, 10'd0, 1'b0, '{'0, '0, '0}},
        // unused code leaves everything alone
        '{CMD_UNUSED, 24'sh7FFFFF, 24'sh7FFFFF, 10'd7, 1'b0, '{'0, '0, '0}},
        '{CMD_READ,  24'sd0, 24'sd0, 10'd513,  1'b0, '{'0, '0, '0}},
        '{CMD_READ,  24'sd0, 24'sd0, 10'd511,  1'b0, '{'0, '0, '0}},
        '{CMD_READ,  24'sd0, 24'sd0, 10'd0,    1'b0, '{'0, '0, '0}},
        // clear then read the loaded bin again
        '{CMD_CLEAR, 24'sd0, 24'sd0, 10'd0,    1'b0, '{'0, '0, '0}},
        '{CMD_READ,  24'sd0, 24'sd0, 10'd512,  1'b1, '{10'd512, 24'd0, 24'd0}}
    };

    // settings walked by the random part: extremes, saturated length, zero divisors,
    // windows longer than the spectrum, even windows
    phase_setting_t phase_settings [NUM_PHASES] = '{
        '{4'd3,  16'd1,     7'd7},
        '{4'd0,  16'd1,     7'd0},
        '{4'd2,  16'd3,     7'd8},
        '{4'd1,  16'd1,     7'd127},
        '{4'd10, 16'd65535, 7'd7},
        '{4'd15, 16'd0,     7'd127},
        '{4'd4,  16'd2,     7'd6},
        '{4'd5,  16'd1,     7'd9},
        '{4'd7,  16'd5,     7'd1},
        '{4'd3,  16'd1,     7'd2}
    };

    initial begin
        bin_report_t none;
        int read_pct;
        int pick;
        none = '{'0, '0, '0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].re, directed_rows[i].im,
                         directed_rows[i].rbin, directed_rows[i].fixed,
                         directed_rows[i].report);

        foreach (phase_settings[p]) begin
            drain_block();
            write_reg(REG_LEN_LOG2, CFG_DATA_W'(phase_settings[p].len_log2));
            write_reg(REG_NUM_LINES, phase_settings[p].lines);
            write_reg(REG_WINDOW, CFG_DATA_W'(phase_settings[p].window));
            // long windows make each read slow, so read less often there
            read_pct = (phase_settings[p].window > 20) ? 3 : 10;
            // start from an empty store, then mostly bins in order with reads between
            send_request(CMD_CLEAR, '0, '0, '0, 1'b0, none);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < read_pct)
                    send_request(CMD_READ, random_sample(), random_sample(),
                                 BIN_W'($urandom), 1'b0, none);
                else if (pick < read_pct + 2)
                    send_request(CMD_CLEAR, random_sample(), random_sample(),
                                 BIN_W'($urandom), 1'b0, none);
                else if (pick < read_pct + 4)
                    send_request(CMD_UNUSED, random_sample(), random_sample(),
                                 BIN_W'($urandom), 1'b0, none);
                else
                    send_request(CMD_ACCUM, random_sample(), random_sample(),
                                 BIN_W'($urandom), 1'b0, none);
            end
        end

        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
